FILE: sv/msb_pkg.sv
// ----------------------------------------------------------------------------
// msb_pkg: shared types for the meshlet split/bounds block
// Field widths, the front-to-back request record, result kinds and back-end states.
// ----------------------------------------------------------------------------
package msb_pkg;

  localparam int unsigned CoordW = 32;
  localparam int unsigned CntW   = 32;
  localparam int unsigned TriW   = 9;

  typedef enum logic {
    KIND_MESHLET = 1'b0,
    KIND_RANGE   = 1'b1
  } kind_t;

  // One closed meshlet (box already final), a mesh range, or both, handed to the back end.
  typedef struct packed {
    logic                     has_meshlet;
    logic                     has_range;
    logic [CntW-1:0]          index_offset;
    logic [TriW-1:0]          triangle_count;
    logic                     has_vertex;
    logic signed [CoordW-1:0] min_x;
    logic signed [CoordW-1:0] min_y;
    logic signed [CoordW-1:0] min_z;
    logic signed [CoordW-1:0] max_x;
    logic signed [CoordW-1:0] max_y;
    logic signed [CoordW-1:0] max_z;
    logic [CntW-1:0]          first_meshlet;
    logic [CntW-1:0]          meshlet_total;
  } job_t;

  typedef enum logic [2:0] {
    BK_IDLE,
    BK_SQ,
    BK_SUM,
    BK_ROOT,
    BK_OUT_MESHLET,
    BK_OUT_RANGE
  } bk_state_t;

endpackage

FILE: sv/msb_if.sv
// ----------------------------------------------------------------------------
// msb_in_if / msb_out_if: valid/ready channels
// Input index requests and output result requests.
// ----------------------------------------------------------------------------
interface msb_in_if;
  logic        valid;
  logic        ready;
  logic        index_present;
  logic [31:0] vertex_index;
  logic [31:0] vertex_count;
  logic signed [31:0] pos_x;
  logic signed [31:0] pos_y;
  logic signed [31:0] pos_z;
  logic        mesh_end;
  modport source (output valid, index_present, vertex_index, vertex_count,
                  pos_x, pos_y, pos_z, mesh_end, input ready);
  modport sink (input valid, index_present, vertex_index, vertex_count,
                pos_x, pos_y, pos_z, mesh_end, output ready);
endinterface

interface msb_out_if;
  logic        valid;
  logic        ready;
  logic        result_kind;
  logic [31:0] index_offset;
  logic [8:0]  triangle_count;
  logic signed [31:0] center_x;
  logic signed [31:0] center_y;
  logic signed [31:0] center_z;
  logic [32:0] sphere_radius;
  logic        bounds_empty;
  logic [31:0] first_meshlet;
  logic [31:0] meshlet_total;
  logic        last_result;
  modport source (output valid, result_kind, index_offset, triangle_count,
                  center_x, center_y, center_z, sphere_radius, bounds_empty,
                  first_meshlet, meshlet_total, last_result, input ready);
  modport sink (input valid, result_kind, index_offset, triangle_count,
                center_x, center_y, center_z, sphere_radius, bounds_empty,
                first_meshlet, meshlet_total, last_result, output ready);
endinterface

FILE: sv/meshlet_split_bounds_core.sv
// ----------------------------------------------------------------------------
// meshlet_split_bounds_core: meshlet splitter with bounding spheres
// Top level: accumulator front, job queue, sphere back end.
// ----------------------------------------------------------------------------
// The front takes one index request per cycle, stalling while the job queue is
// full, and folds its vertex into the triangle and meshlet boxes. A closed
// meshlet or a mesh end becomes one job in a four-entry queue. The back end
// works on one job at a time: a meshlet job passes through squaring of the three
// half-extents, a sum and a 33-step radix-4 square root, then hands out its
// results as the output takes them. Input thus runs at one per cycle until the
// queue fills; sustained, the square-root unit sets the limit.
module meshlet_split_bounds_core #(
  parameter int unsigned MAX_TRIANGLES = 64
) (
  input  logic      clk,
  input  logic      rst_n,
  msb_in_if.sink    in_ch,
  msb_out_if.source out_ch
);

  logic          fj_valid, fj_ready, bj_valid, bj_ready;
  msb_pkg::job_t fj, bj;

  msb_front #(.MAX_TRIANGLES(MAX_TRIANGLES)) u_front (
    .clk, .rst_n, .in_ch, .job_valid(fj_valid), .job(fj), .job_ready(fj_ready)
  );

  msb_queue #(.DEPTH(4)) u_queue (
    .clk, .rst_n, .wr_valid(fj_valid), .wr_ready(fj_ready), .wr_data(fj),
    .rd_valid(bj_valid), .rd_ready(bj_ready), .rd_data(bj)
  );

  msb_back u_back (
    .clk, .rst_n, .job_valid(bj_valid), .job_ready(bj_ready), .job(bj), .out_ch
  );

endmodule

FILE: sv/msb_front.sv
// ----------------------------------------------------------------------------
// msb_front: index accumulator
// Folds vertices into triangle and meshlet boxes, counts, and issues jobs.
// ----------------------------------------------------------------------------
module msb_front #(
  parameter int unsigned MAX_TRIANGLES = 64
) (
  input  logic          clk,
  input  logic          rst_n,
  msb_in_if.sink        in_ch,
  output logic          job_valid,
  output msb_pkg::job_t job,
  input  logic          job_ready
);

  logic signed [31:0] tmin_r [3], tmax_r [3], mmin_r [3], mmax_r [3];
  logic signed [31:0] tmin_nxt [3], tmax_nxt [3], mmin_nxt [3], mmax_nxt [3];
  logic        thas_r, mhas_r, thas_nxt, mhas_nxt;
  logic [1:0]  corner_r, corner_nxt;
  logic [8:0]  tris_r, tris_nxt;
  logic [31:0] idx_r, idx_nxt, emitted_r, emitted_nxt, first_r, first_nxt;
  logic [31:0] cnt_r, cnt_nxt;
  logic        accept, in_rng, full;
  logic signed [31:0] p [3];
  msb_pkg::job_t job_c;

  assign in_ch.ready = job_ready;
  assign accept = in_ch.valid & in_ch.ready;
  assign p[0] = in_ch.pos_x;
  assign p[1] = in_ch.pos_y;
  assign p[2] = in_ch.pos_z;
  assign in_rng = in_ch.vertex_index < in_ch.vertex_count;

  always_comb begin
    thas_nxt = thas_r; mhas_nxt = mhas_r; corner_nxt = corner_r;
    tris_nxt = tris_r; idx_nxt = idx_r; emitted_nxt = emitted_r;
    first_nxt = first_r; cnt_nxt = cnt_r;
    for (int c = 0; c < 3; c++) begin
      tmin_nxt[c] = tmin_r[c]; tmax_nxt[c] = tmax_r[c];
      mmin_nxt[c] = mmin_r[c]; mmax_nxt[c] = mmax_r[c];
    end
    full = 1'b0;
    job_c = '0;
    if (in_ch.index_present) begin
      if (in_rng) begin
        for (int c = 0; c < 3; c++) begin
          if (!thas_r || p[c] < tmin_r[c]) tmin_nxt[c] = p[c];
          if (!thas_r || p[c] > tmax_r[c]) tmax_nxt[c] = p[c];
        end
        thas_nxt = 1'b1;
      end
      if (corner_r == 2'd2) begin
        corner_nxt = 2'd0;
        if (thas_nxt) begin
          for (int c = 0; c < 3; c++) begin
            if (!mhas_r || tmin_nxt[c] < mmin_r[c]) mmin_nxt[c] = tmin_nxt[c];
            if (!mhas_r || tmax_nxt[c] > mmax_r[c]) mmax_nxt[c] = tmax_nxt[c];
          end
          mhas_nxt = 1'b1;
        end
        thas_nxt = 1'b0;
        tris_nxt = tris_r + 9'd1;
        idx_nxt = idx_r + 32'd3;
        full = ({23'd0, tris_nxt} >= 32'(MAX_TRIANGLES));
      end else begin
        corner_nxt = corner_r + 2'd1;
      end
    end
    // meshlet closes when full, or at mesh end with triangles open
    job_c.has_meshlet = full || (in_ch.mesh_end && tris_nxt != 9'd0);
    job_c.has_range = in_ch.mesh_end;
    job_c.index_offset = idx_nxt - 32'(3 * tris_nxt);
    job_c.triangle_count = tris_nxt;
    job_c.has_vertex = mhas_nxt;
    job_c.min_x = mmin_nxt[0]; job_c.min_y = mmin_nxt[1]; job_c.min_z = mmin_nxt[2];
    job_c.max_x = mmax_nxt[0]; job_c.max_y = mmax_nxt[1]; job_c.max_z = mmax_nxt[2];
    if (job_c.has_meshlet) begin
      emitted_nxt = emitted_r + 32'd1;
      cnt_nxt = cnt_r + 32'd1;
      tris_nxt = '0;
      mhas_nxt = 1'b0;
    end
    job_c.first_meshlet = first_r;
    job_c.meshlet_total = cnt_nxt;
    if (in_ch.mesh_end) begin
      first_nxt = emitted_nxt;
      cnt_nxt = '0;
      corner_nxt = '0;
      thas_nxt = 1'b0;
      tris_nxt = '0;
      mhas_nxt = 1'b0;
    end
  end

  assign job_valid = accept & (job_c.has_meshlet | job_c.has_range);
  assign job = job_c;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      thas_r <= 1'b0; mhas_r <= 1'b0; corner_r <= '0; tris_r <= '0;
      idx_r <= '0; emitted_r <= '0; first_r <= '0; cnt_r <= '0;
    end else if (accept) begin
      thas_r <= thas_nxt; mhas_r <= mhas_nxt; corner_r <= corner_nxt;
      tris_r <= tris_nxt; idx_r <= idx_nxt; emitted_r <= emitted_nxt;
      first_r <= first_nxt; cnt_r <= cnt_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      for (int c = 0; c < 3; c++) begin
        tmin_r[c] <= tmin_nxt[c]; tmax_r[c] <= tmax_nxt[c];
        mmin_r[c] <= mmin_nxt[c]; mmax_r[c] <= mmax_nxt[c];
      end
    end
  end

endmodule

FILE: sv/msb_queue.sv
// ----------------------------------------------------------------------------
// msb_queue: job FIFO
// Small register FIFO between accumulator and sphere stage.
// ----------------------------------------------------------------------------
module msb_queue #(
  parameter int unsigned DEPTH = 4
) (
  input  logic          clk,
  input  logic          rst_n,
  input  logic          wr_valid,
  output logic          wr_ready,
  input  msb_pkg::job_t wr_data,
  output logic          rd_valid,
  input  logic          rd_ready,
  output msb_pkg::job_t rd_data
);

  localparam int unsigned AW = (DEPTH > 1) ? $clog2(DEPTH) : 1;

  msb_pkg::job_t mem [DEPTH];
  logic [AW-1:0] wp_r, rp_r;
  logic [AW:0]   cnt_r;
  logic          wr, rd;

  assign wr_ready = cnt_r != (AW+1)'(DEPTH);
  assign rd_valid = cnt_r != '0;
  assign wr = wr_valid & wr_ready;
  assign rd = rd_valid & rd_ready;
  assign rd_data = mem[rp_r];

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wp_r <= '0; rp_r <= '0; cnt_r <= '0;
    end else begin
      if (wr) wp_r <= (wp_r == AW'(DEPTH-1)) ? '0 : wp_r + 1'b1;
      if (rd) rp_r <= (rp_r == AW'(DEPTH-1)) ? '0 : rp_r + 1'b1;
      cnt_r <= cnt_r + (AW+1)'(wr) - (AW+1)'(rd);
    end
  end

  always_ff @(posedge clk) begin
    if (wr) mem[wp_r] <= wr_data;
  end

endmodule

FILE: sv/msb_back.sv
// ----------------------------------------------------------------------------
// msb_back: sphere stage
// Centre, squared half-extents, bit-pair integer square root, result output.
// ----------------------------------------------------------------------------
module msb_back (
  input  logic          clk,
  input  logic          rst_n,
  input  logic          job_valid,
  output logic          job_ready,
  input  msb_pkg::job_t job,
  msb_out_if.source     out_ch
);

  msb_pkg::bk_state_t st_r, st_nxt;
  msb_pkg::job_t job_r;
  logic signed [31:0] ctr_r [3];
  logic [31:0] h_r [3];
  logic [63:0] sq_r [3];
  logic [1:0]  ax_r;
  logic [65:0] num_r, rem_r;
  logic [32:0] root_r;
  logic [5:0]  step_r;
  logic signed [32:0] lo [3], hi [3], s, d;
  logic [67:0] trial, rem_sh;
  logic        out_fire;

  assign lo[0] = 33'(job_r.min_x);
  assign hi[0] = 33'(job_r.max_x);
  assign lo[1] = 33'(job_r.min_y);
  assign hi[1] = 33'(job_r.max_y);
  assign lo[2] = 33'(job_r.min_z);
  assign hi[2] = 33'(job_r.max_z);

  assign out_fire = out_ch.valid & out_ch.ready;
  assign job_ready = st_r == msb_pkg::BK_IDLE;

  // restoring root: two radicand bits per step, 33 steps
  assign rem_sh = {rem_r, num_r[65:64]};
  assign trial  = {33'd0, root_r, 2'b01};

  always_comb begin
    st_nxt = st_r;
    unique case (st_r)
      msb_pkg::BK_IDLE:
        if (job_valid) st_nxt = job.has_meshlet ? msb_pkg::BK_SQ : msb_pkg::BK_OUT_RANGE;
      msb_pkg::BK_SQ:   if (ax_r == 2'd2) st_nxt = msb_pkg::BK_SUM;
      msb_pkg::BK_SUM:  st_nxt = msb_pkg::BK_ROOT;
      msb_pkg::BK_ROOT: if (step_r == 6'd32) st_nxt = msb_pkg::BK_OUT_MESHLET;
      msb_pkg::BK_OUT_MESHLET:
        if (out_fire) st_nxt = job_r.has_range ? msb_pkg::BK_OUT_RANGE : msb_pkg::BK_IDLE;
      msb_pkg::BK_OUT_RANGE: if (out_fire) st_nxt = msb_pkg::BK_IDLE;
      default: st_nxt = msb_pkg::BK_IDLE;
    endcase
  end

  always_comb begin
    out_ch.valid = 1'b0;
    out_ch.result_kind = msb_pkg::KIND_MESHLET;
    out_ch.index_offset = '0; out_ch.triangle_count = '0;
    out_ch.center_x = '0; out_ch.center_y = '0; out_ch.center_z = '0;
    out_ch.sphere_radius = '0; out_ch.bounds_empty = 1'b0;
    out_ch.first_meshlet = '0; out_ch.meshlet_total = '0;
    out_ch.last_result = 1'b0;
    unique case (st_r)
      msb_pkg::BK_OUT_MESHLET: begin
        out_ch.valid = 1'b1;
        out_ch.index_offset = job_r.index_offset;
        out_ch.triangle_count = job_r.triangle_count;
        if (job_r.has_vertex) begin
          out_ch.center_x = ctr_r[0]; out_ch.center_y = ctr_r[1];
          out_ch.center_z = ctr_r[2]; out_ch.sphere_radius = root_r;
        end
        out_ch.bounds_empty = !job_r.has_vertex;
        out_ch.last_result = !job_r.has_range;
      end
      msb_pkg::BK_OUT_RANGE: begin
        out_ch.valid = 1'b1;
        out_ch.result_kind = msb_pkg::KIND_RANGE;
        out_ch.first_meshlet = job_r.first_meshlet;
        out_ch.meshlet_total = job_r.meshlet_total;
        out_ch.last_result = 1'b1;
      end
      default: ;
    endcase
  end

  always_comb begin
    s = hi[ax_r] + lo[ax_r];
    d = hi[ax_r] - lo[ax_r];
  end

  always_ff @(posedge clk) begin
    if (!rst_n) st_r <= msb_pkg::BK_IDLE;
    else st_r <= st_nxt;
  end

  always_ff @(posedge clk) begin
    unique case (st_r)
      msb_pkg::BK_IDLE: begin
        job_r <= job;
        ax_r <= '0;
      end
      msb_pkg::BK_SQ: begin
        ctr_r[ax_r] <= 32'(s >>> 1);
        h_r[ax_r] <= 32'(d[32:1]);
        if (ax_r != 2'd2) ax_r <= ax_r + 2'd1;
        if (ax_r != 2'd0) sq_r[ax_r-2'd1] <= h_r[ax_r-2'd1] * h_r[ax_r-2'd1];
      end
      msb_pkg::BK_SUM: begin
        num_r <= 66'(sq_r[0]) + 66'(sq_r[1]) + 66'(h_r[2]) * 66'(h_r[2]);
        rem_r <= '0;
        root_r <= '0;
        step_r <= '0;
      end
      msb_pkg::BK_ROOT: begin
        num_r <= {num_r[63:0], 2'b00};
        step_r <= step_r + 6'd1;
        if (rem_sh >= trial) begin
          rem_r <= 66'(rem_sh - trial);
          root_r <= {root_r[31:0], 1'b1};
        end else begin
          rem_r <= 66'(rem_sh);
          root_r <= {root_r[31:0], 1'b0};
        end
      end
      default: ;
    endcase
  end

endmodule

FILE: sv/msb_checker.sv
// ----------------------------------------------------------------------------
// msb_checker: port-level checks
// Output handshake and result-field rules.
// ----------------------------------------------------------------------------
module msb_checker (
  input logic clk,
  input logic rst_n,
  input logic out_valid,
  input logic out_ready,
  input logic out_result_kind,
  input logic out_bounds_empty,
  input logic [32:0] out_sphere_radius,
  input logic out_last_result
);

  a_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_ready |=> out_valid) else $error("valid dropped");
  a_range_last: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_result_kind |-> out_last_result) else $error("range not last");
  a_empty: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_bounds_empty |-> out_sphere_radius == '0) else $error("empty radius");
  a_range_fields: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_result_kind |-> !out_bounds_empty) else $error("range empty");

endmodule

bind meshlet_split_bounds_core msb_checker u_chk (
  .clk, .rst_n, .out_valid(out_ch.valid), .out_ready(out_ch.ready),
  .out_result_kind(out_ch.result_kind), .out_bounds_empty(out_ch.bounds_empty),
  .out_sphere_radius(out_ch.sphere_radius), .out_last_result(out_ch.last_result)
);
